// ===== rtl/txmsq_pkg.sv =====
// Shared types and constants for the transmit message slot queue.
// No dependencies; imported by the controller, datapath, top level and bench.
`timescale 1ns / 1ps

package txmsq_pkg;

    // action field codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_POLL    = 1'b1;

    // slot state codes
    typedef logic [1:0] t_slot_state;
    localparam t_slot_state SLOT_FREE    = 2'd0;
    localparam t_slot_state SLOT_OPEN    = 2'd1;
    localparam t_slot_state SLOT_PENDING = 2'd2;

    localparam logic [7:0] PRIORITY_BITS = 8'hB0;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    // one stored message
    typedef struct packed {
        logic [7:0]      opcode;
        logic [2:0]      len;
        logic [6:0][7:0] bytes;
    } t_msg;

    // controller to datapath
    typedef struct packed {
        logic enq_go;     // enqueue transfer taken
        logic poll_go;    // poll with idle transmitter taken
        logic busy_go;    // poll with busy transmitter taken
        logic frame_go;   // read data ready, load frame result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_stat;

endpackage

// ===== rtl/txmsq_ctrl.sv =====
// Controller for the transmit message slot queue: input handshake and sequencing.
// Depends on txmsq_pkg.
`timescale 1ns / 1ps

module txmsq_ctrl
    import txmsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_out_stall,
    input  logic  i_action,
    input  logic  i_tx_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // hold input during the memory read or while a result cannot be delivered this cycle
    assign o_in_stall = (r_state != ST_IDLE) || (i_stat.out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.enq_go   = accept && (i_action == ACT_ENQUEUE);
        o_cmd.poll_go  = accept && (i_action == ACT_POLL) && !i_tx_busy;
        o_cmd.busy_go  = accept && (i_action == ACT_POLL) && i_tx_busy;
        o_cmd.frame_go = (r_state == ST_READ);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.poll_go) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/txmsq_dp.sv =====
// Datapath for the transmit message slot queue: slot states, message memory,
// slot search, configuration register and output register. Depends on txmsq_pkg.
`timescale 1ns / 1ps

module txmsq_dp
    import txmsq_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  t_msg       i_msg,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_accepted,
    output logic       o_launched,
    output logic [7:0] o_id_high,
    output logic [3:0] o_length_code,
    output t_msg       o_frame
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_slot_state r_slot [SLOT_COUNT];
    t_msg        r_mem  [SLOT_COUNT];
    t_msg        r_rd_data;
    logic        r_found;
    logic [3:0]  r_nibble;

    logic [SLOT_COUNT-1:0] free_vec;
    logic [SLOT_COUNT-1:0] open_vec;
    logic [SLOT_COUNT-1:0] free_hot;
    logic [SLOT_COUNT-1:0] open_hot;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      open_idx;

    // lowest set bit, then encode the one-hot vector
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            free_vec[i] = (r_slot[i] == SLOT_FREE);
            open_vec[i] = (r_slot[i] == SLOT_OPEN);
        end
        free_hot = free_vec & (~free_vec + 1'b1);
        open_hot = open_vec & (~open_vec + 1'b1);
        free_idx = '0;
        open_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (free_hot[i]) free_idx = free_idx | IDX_W'(i);
            if (open_hot[i]) open_idx = open_idx | IDX_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= SLOT_FREE;
            end
        end else if (i_cmd.enq_go) begin
            if (free_hot != '0) begin
                r_slot[free_idx] <= SLOT_OPEN;
            end
        end else if (i_cmd.poll_go) begin
            // drop pending slots, promote the lowest open one
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (open_hot[i]) begin
                    r_slot[i] <= SLOT_PENDING;
                end else if (r_slot[i] == SLOT_PENDING) begin
                    r_slot[i] <= SLOT_FREE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_go && (free_hot != '0)) begin
            r_mem[free_idx] <= i_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.poll_go) begin
            r_rd_data <= r_mem[open_idx];
            r_found   <= (open_hot != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble <= '0;
        end else if (i_cfg_we) begin
            r_nibble <= i_cfg_data & NIBBLE_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.enq_go || i_cmd.busy_go || i_cmd.frame_go) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_go || i_cmd.busy_go || i_cmd.frame_go) begin
            o_accepted <= i_cmd.enq_go && (free_hot != '0);
            if (i_cmd.frame_go && r_found) begin
                o_launched    <= 1'b1;
                o_id_high     <= PRIORITY_BITS | {4'b0000, r_nibble};
                o_length_code <= {1'b0, r_rd_data.len} + 4'd1;
                o_frame       <= r_rd_data;
            end else begin
                o_launched    <= 1'b0;
                o_id_high     <= '0;
                o_length_code <= '0;
                o_frame       <= '0;
            end
        end
    end

    assign o_stat.out_valid = o_out_valid;

endmodule

// ===== rtl/tx_message_slot_queue_core.sv =====
// Transmit message slot queue, top level: controller, datapath and ports.
// Depends on txmsq_pkg, txmsq_ctrl and txmsq_dp.
//
// Usage: each input transfer is an enqueue (action 0) or a transmitter poll
// (action 1). Every input transfer yields exactly one result transfer.
// Enqueue stores the message in the lowest free slot and reports whether one was free.
// A poll with tx_busy low frees pending slots, then launches the lowest open
// slot as a frame; a poll with tx_busy high changes nothing.
// Timing: the result of an enqueue or a busy poll is registered and valid the
// cycle after the transfer. An idle poll first reads the message memory into a
// register, then the result register is loaded from the read data; the input
// stalls during the read.
// Throughput: one item per cycle for enqueues and busy polls while no result is
// stalled; an idle poll holds off the next item until its read is done.
// Stall: while a result waits with out_stall high, the input is stalled.
// Reset: synchronous, active low; all slots free, nibble register 0, no
// result pending. No clearing pass. The config port is always ready.
`timescale 1ns / 1ps

module tx_message_slot_queue_core
    import txmsq_pkg::*;
#(
    parameter int SLOT_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic       i_tx_busy,
    input  logic [7:0] i_opcode,
    input  logic [2:0] i_data_len,
    input  logic [7:0] i_data0,
    input  logic [7:0] i_data1,
    input  logic [7:0] i_data2,
    input  logic [7:0] i_data3,
    input  logic [7:0] i_data4,
    input  logic [7:0] i_data5,
    input  logic [7:0] i_data6,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_accepted,
    output logic       o_launched,
    output logic [7:0] o_id_high,
    output logic [3:0] o_length_code,
    output logic [7:0] o_frame_opcode,
    output logic [7:0] o_out_data0,
    output logic [7:0] o_out_data1,
    output logic [7:0] o_out_data2,
    output logic [7:0] o_out_data3,
    output logic [7:0] o_out_data4,
    output logic [7:0] o_out_data5,
    output logic [7:0] o_out_data6
);

    t_cmd  cmd;
    t_stat stat;
    t_msg  in_msg;
    t_msg  out_msg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_msg.opcode   = i_opcode;
        in_msg.len      = i_data_len;
        in_msg.bytes[0] = i_data0;
        in_msg.bytes[1] = i_data1;
        in_msg.bytes[2] = i_data2;
        in_msg.bytes[3] = i_data3;
        in_msg.bytes[4] = i_data4;
        in_msg.bytes[5] = i_data5;
        in_msg.bytes[6] = i_data6;
    end

    txmsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_action    (i_action),
        .i_tx_busy   (i_tx_busy),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    txmsq_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_msg         (in_msg),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_accepted    (o_accepted),
        .o_launched    (o_launched),
        .o_id_high     (o_id_high),
        .o_length_code (o_length_code),
        .o_frame       (out_msg)
    );

    // the stored length field travels as length_code instead
    assign o_frame_opcode = out_msg.opcode;
    assign o_out_data0    = out_msg.bytes[0];
    assign o_out_data1    = out_msg.bytes[1];
    assign o_out_data2    = out_msg.bytes[2];
    assign o_out_data3    = out_msg.bytes[3];
    assign o_out_data4    = out_msg.bytes[4];
    assign o_out_data5    = out_msg.bytes[5];
    assign o_out_data6    = out_msg.bytes[6];

endmodule

// ===== rtl/txmsq_chk.sv =====
// Port-level checks for the transmit message slot queue, bound to the top level.
// Depends on tx_message_slot_queue_core port names only.
`timescale 1ns / 1ps

module txmsq_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_accepted,
    input logic       o_launched,
    input logic [7:0] o_id_high,
    input logic [3:0] o_length_code
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // no new input transfer while a result is stuck
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    // enqueue and launch results are exclusive
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_launched))
        else $error("result both accepted and launched");

    // a launched frame carries priority bits and a length code of 1 to 8
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_launched |->
            (o_id_high[7:4] == 4'hB) && (o_length_code != 4'd0) && !(o_length_code > 4'd8))
        else $error("malformed launched frame");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind tx_message_slot_queue_core txmsq_chk u_chk (.*);

// ===== test/tb.sv =====
// Self-checking bench for tx_message_slot_queue_core: directed and random enqueue/poll
// traffic, checked against a behavioral slot table kept in the bench.
// Depends on txmsq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
    import txmsq_pkg::*;
();

    localparam int NUM_SLOTS   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 4000;

    typedef struct packed {
        logic action;
        logic tx_busy;
        t_msg msg;
    } t_slot_cmd;

    typedef struct packed {
        logic            accepted;
        logic            launched;
        logic [7:0]      id_high;
        logic [3:0]      length_code;
        logic [7:0]      frame_opcode;
        logic [6:0][7:0] bytes;
    } t_slot_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_action;
    logic       i_tx_busy;
    logic [7:0] i_opcode;
    logic [2:0] i_data_len;
    logic [7:0] i_data0, i_data1, i_data2, i_data3, i_data4, i_data5, i_data6;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_accepted;
    logic       o_launched;
    logic [7:0] o_id_high;
    logic [3:0] o_length_code;
    logic [7:0] o_frame_opcode;
    logic [7:0] o_out_data0, o_out_data1, o_out_data2, o_out_data3;
    logic [7:0] o_out_data4, o_out_data5, o_out_data6;

    tx_message_slot_queue_core #(
        .SLOT_COUNT(NUM_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_tx_busy     (i_tx_busy),
        .i_opcode      (i_opcode),
        .i_data_len    (i_data_len),
        .i_data0       (i_data0),
        .i_data1       (i_data1),
        .i_data2       (i_data2),
        .i_data3       (i_data3),
        .i_data4       (i_data4),
        .i_data5       (i_data5),
        .i_data6       (i_data6),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accepted    (o_accepted),
        .o_launched    (o_launched),
        .o_id_high     (o_id_high),
        .o_length_code (o_length_code),
        .o_frame_opcode(o_frame_opcode),
        .o_out_data0   (o_out_data0),
        .o_out_data1   (o_out_data1),
        .o_out_data2   (o_out_data2),
        .o_out_data3   (o_out_data3),
        .o_out_data4   (o_out_data4),
        .o_out_data5   (o_out_data5),
        .o_out_data6   (o_out_data6)
    );

    // bench copy of the slot table and the nibble register
    t_slot_state  table_state [NUM_SLOTS];
    t_msg         table_msg   [NUM_SLOTS];
    logic [3:0]   id_nibble;
    t_slot_result results_due [$];

    int send_idle_pct;
    int stall_pct;
    int cycle_count;
    int mismatches;
    int items_sent;
    int results_seen;
    int enq_stored;
    int enq_rejected;
    int frames_launched;
    int busy_polls;
    int nibble_writes;

    t_slot_result got_result;
    t_slot_result want_result;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     results_due.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // One slot table step: enqueue into the lowest free slot, or on an idle poll
    // free all pending slots and launch the lowest open one.
    function automatic t_slot_result step_slot_table(input t_slot_cmd cmd);
        t_slot_result res;
        logic         found;
        res   = '0;
        found = 1'b0;
        if (cmd.action == ACT_ENQUEUE) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!found && table_state[i] == SLOT_FREE) begin
                    table_msg[i]   = cmd.msg;
                    table_state[i] = SLOT_OPEN;
                    res.accepted   = 1'b1;
                    found          = 1'b1;
                end
            end
        end else if (!cmd.tx_busy) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (table_state[i] == SLOT_PENDING) begin
                    table_state[i] = SLOT_FREE;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!found && table_state[i] == SLOT_OPEN) begin
                    table_state[i]   = SLOT_PENDING;
                    res.launched     = 1'b1;
                    res.id_high      = PRIORITY_BITS | {4'h0, id_nibble & NIBBLE_MASK};
                    res.length_code  = {1'b0, table_msg[i].len} + 4'd1;
                    res.frame_opcode = table_msg[i].opcode;
                    res.bytes        = table_msg[i].bytes;
                    found            = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_slot_cmd make_cmd(input logic action, input logic busy,
                                           input logic [7:0] opcode, input logic [2:0] len,
                                           input logic [55:0] bytes);
        t_slot_cmd cmd;
        cmd.action     = action;
        cmd.tx_busy    = busy;
        cmd.msg.opcode = opcode;
        cmd.msg.len    = len;
        cmd.msg.bytes  = bytes;
        return cmd;
    endfunction

    function automatic t_slot_cmd random_cmd(input int enq_pct, input int busy_pct);
        return make_cmd(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_POLL,
                        $urandom_range(99) < busy_pct, 8'($urandom_range(255)),
                        3'($urandom_range(7)), 56'({$urandom, $urandom}));
    endfunction

    // Present one item at a falling edge and hold it until the transfer.
    task automatic send_cmd(input t_slot_cmd cmd);
        t_slot_result res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action   = cmd.action;
        i_tx_busy  = cmd.tx_busy;
        i_opcode   = cmd.msg.opcode;
        i_data_len = cmd.msg.len;
        i_data0    = cmd.msg.bytes[0];
        i_data1    = cmd.msg.bytes[1];
        i_data2    = cmd.msg.bytes[2];
        i_data3    = cmd.msg.bytes[3];
        i_data4    = cmd.msg.bytes[4];
        i_data5    = cmd.msg.bytes[5];
        i_data6    = cmd.msg.bytes[6];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = step_slot_table(cmd);
        results_due.push_back(res);
        items_sent++;
        if (cmd.action == ACT_ENQUEUE) begin
            if (res.accepted) enq_stored++;
            else enq_rejected++;
        end else if (cmd.tx_busy) begin
            busy_polls++;
        end else if (res.launched) begin
            frames_launched++;
        end
        @(negedge i_clk);
    endtask

    // Write the nibble register once the block has drained.
    task automatic write_nibble(input logic [3:0] value);
        i_in_valid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        id_nibble = value;
        nibble_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic report_result(input string what, input t_slot_result want,
                                 input t_slot_result got);
        if (mismatches < 10) begin
            $display("%s at cycle %0d: acc %b/%b lau %b/%b id %h/%h len %h/%h op %h/%h",
                     what, cycle_count, want.accepted, got.accepted, want.launched,
                     got.launched, want.id_high, got.id_high, want.length_code,
                     got.length_code, want.frame_opcode, got.frame_opcode);
            $display("    data exp %h got %h", want.bytes, got.bytes);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_result = {o_accepted, o_launched, o_id_high, o_length_code, o_frame_opcode,
                          o_out_data6, o_out_data5, o_out_data4, o_out_data3,
                          o_out_data2, o_out_data1, o_out_data0};
            results_seen++;
            if (results_due.size() == 0) begin
                report_result("unexpected result", '0, got_result);
            end else begin
                want_result = results_due.pop_front();
                if (got_result !== want_result) begin
                    report_result("result mismatch", want_result, got_result);
                end
            end
        end
    end

    // Polls against an empty table, idle and busy.
    task automatic test_empty_table();
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
        send_cmd(make_cmd(ACT_POLL, 1'b1, 8'hFF, 3'd7, '1));
    endtask

    // Fill every slot with extreme field values, then overflow.
    task automatic test_full_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_cmd(make_cmd(ACT_ENQUEUE, i[0], i[0] ? 8'hFF : 8'h00, i[2:0],
                              i[0] ? 56'h0 : {7{8'hFF}}));
        end
        send_cmd(make_cmd(ACT_ENQUEUE, 1'b0, 8'hA5, 3'd3, 56'h0123456789ABCD));
    endtask

    // Launch order follows slot index: a freed low slot is served before older ones.
    task automatic test_slot_order();
        send_cmd(make_cmd(ACT_POLL, 1'b1, 8'h00, 3'd0, '0));
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
        send_cmd(make_cmd(ACT_ENQUEUE, 1'b0, 8'h5A, 3'd5, 56'hFEDCBA98765432));
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
    endtask

    // Both ends of the nibble register on launched frames.
    task automatic test_nibble_extremes();
        write_nibble(4'hF);
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
        write_nibble(4'h0);
        send_cmd(make_cmd(ACT_POLL, 1'b0, 8'h00, 3'd0, '0));
    endtask

    // Random traffic in batches of 20 that each lean at random toward filling or draining the table.
    task automatic test_random_traffic(input int idle_pct, input int stall_level,
                                       input int count, input logic [3:0] nibble);
        int enq_pct;
        write_nibble(nibble);
        send_idle_pct = idle_pct;
        stall_pct     = stall_level;
        enq_pct       = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                enq_pct = $urandom_range(1) ? 80 : 30;
            end
            send_cmd(random_cmd(enq_pct, 25));
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        int drain_wait;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_action      = ACT_ENQUEUE;
        i_tx_busy     = 1'b0;
        i_opcode      = '0;
        i_data_len    = '0;
        i_data0       = '0;
        i_data1       = '0;
        i_data2       = '0;
        i_data3       = '0;
        i_data4       = '0;
        i_data5       = '0;
        i_data6       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        id_nibble     = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            table_state[i] = SLOT_FREE;
            table_msg[i]   = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_full_table();
        test_slot_order();
        test_nibble_extremes();
        test_random_traffic(0, 0, 330, 4'hF);
        test_random_traffic(74, 0, 330, 4'($urandom_range(15)));
        test_random_traffic(0, 74, 330, 4'h0);
        test_random_traffic(34, 34, 330, 4'($urandom_range(15)));

        i_in_valid = 1'b0;
        drain_wait = 0;
        while (results_due.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $display("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        $display("Sent %0d items (%0d stored, %0d rejected full, %0d busy polls), %0d results",
                 items_sent, enq_stored, enq_rejected, busy_polls, results_seen);
        $display("Launched %0d frames over %0d nibble settings; %0d mismatches",
                 frames_launched, nibble_writes, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
